FILE: rtl/core/rsi_pkg.sv
`default_nettype none
package rsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WW        = 32;
    localparam int LEN_W     = 2 * WW;
    localparam int PROJ_W    = 2 * WW + 2;
    localparam int CQ_W      = 2 * WW + 3;
    localparam int DSC_W     = 2 * PROJ_W;
    localparam int SQ_NW     = DSC_W;
    localparam int SQ_QW     = DSC_W / 2;
    localparam int SQ_RW     = SQ_QW + 3;
    localparam int NUM_W     = SQ_QW + 2;
    localparam int NUM_MW    = NUM_W - 1;
    localparam int DV_NW     = NUM_MW + FRAC_BITS;
    localparam int DV_RW     = LEN_W + 1;
    localparam int MC_AW     = DV_NW;
    localparam int MC_DW     = 16;
    localparam int MC_BW     = 80;
    localparam int MC_PW     = MC_AW + MC_BW;
    localparam int MC_N_DSC  = MC_BW / MC_DW;
    localparam int MC_N_PT   = WW / MC_DW;
    localparam int TERM_W    = DV_NW + WW - FRAC_BITS;
    localparam int SUM_W     = TERM_W + 2;

    localparam logic [WW-1:0] NEG_ONE = ~((WW'(1) << FRAC_BITS) - WW'(1));

    typedef logic signed [WW-1:0] t_word;

    typedef struct packed {
        t_word [2:0]        org;
        t_word [2:0]        dir;
        logic [LEN_W-1:0]   len2;
        logic [PROJ_W-1:0]  proj;
        logic               cq_neg;
        logic               bad;
        logic               hit;
        logic               num_neg;
    } t_side;

    typedef struct packed {
        logic               hit;
        logic               bad;
        logic [WW-1:0]      near_t;
        logic [2:0][WW-1:0] pt;
    } t_res;

    function automatic logic [WW-1:0] sat32(input logic [SUM_W-1:0] v);
        logic [SUM_W-WW:0] top;
        logic [WW-1:0]     res;
        top = v[SUM_W-1:WW-1];
        if (top == '0 || top == '1) begin
            res = v[WW-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(WW-1){1'b0}}};
        end else begin
            res = {1'b0, {(WW-1){1'b1}}};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rsi_mul_cell.sv
`default_nettype none
module rsi_mul_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rsi_pkg::t_side              i_side,
    input  logic [rsi_pkg::MC_AW-1:0]   i_a,
    input  logic [rsi_pkg::MC_BW-1:0]   i_b,
    input  logic [rsi_pkg::MC_PW-1:0]   i_acc,
    output logic                        o_valid,
    output rsi_pkg::t_side              o_side,
    output logic [rsi_pkg::MC_AW-1:0]   o_a,
    output logic [rsi_pkg::MC_BW-1:0]   o_b,
    output logic [rsi_pkg::MC_PW-1:0]   o_acc
);
    import rsi_pkg::*;

    logic [MC_AW+MC_DW-1:0] w_pp;
    logic [MC_PW-1:0]       n_acc;
    logic                   r_valid;
    t_side                  r_side;
    logic [MC_AW-1:0]       r_a;
    logic [MC_BW-1:0]       r_b;
    logic [MC_PW-1:0]       r_acc;

    // msb digit first: shift partial sum up, add next digit product
    assign w_pp  = (MC_AW+MC_DW)'(i_a) * (MC_AW+MC_DW)'(i_b[MC_BW-1 -: MC_DW]);
    assign n_acc = {i_acc[MC_PW-MC_DW-1:0], {MC_DW{1'b0}}} + MC_PW'(w_pp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_a    <= i_a;
            r_b    <= {i_b[MC_BW-MC_DW-1:0], {MC_DW{1'b0}}};
            r_acc  <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_acc   = r_acc;

endmodule
`default_nettype wire

FILE: rtl/core/rsi_sqrt_cell.sv
`default_nettype none
module rsi_sqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rsi_pkg::t_side              i_side,
    input  logic [rsi_pkg::SQ_NW-1:0]   i_num,
    input  logic [rsi_pkg::SQ_RW-1:0]   i_rem,
    input  logic [rsi_pkg::SQ_QW-1:0]   i_root,
    output logic                        o_valid,
    output rsi_pkg::t_side              o_side,
    output logic [rsi_pkg::SQ_NW-1:0]   o_num,
    output logic [rsi_pkg::SQ_RW-1:0]   o_rem,
    output logic [rsi_pkg::SQ_QW-1:0]   o_root
);
    import rsi_pkg::*;

    logic [SQ_RW-1:0] w_rem2;
    logic [SQ_RW-1:0] w_trial;
    logic             w_ge;
    logic             r_valid;
    t_side            r_side;
    logic [SQ_NW-1:0] r_num;
    logic [SQ_RW-1:0] r_rem;
    logic [SQ_QW-1:0] r_root;

    assign w_rem2  = {i_rem[SQ_RW-3:0], i_num[SQ_NW-1 -: 2]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_num  <= {i_num[SQ_NW-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {i_root[SQ_QW-2:0], w_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule
`default_nettype wire

FILE: rtl/core/rsi_div_cell.sv
`default_nettype none
module rsi_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rsi_pkg::t_side              i_side,
    input  logic [rsi_pkg::DV_NW-1:0]   i_num,
    input  logic [rsi_pkg::DV_RW-1:0]   i_rem,
    input  logic [rsi_pkg::DV_NW-1:0]   i_quo,
    output logic                        o_valid,
    output rsi_pkg::t_side              o_side,
    output logic [rsi_pkg::DV_NW-1:0]   o_num,
    output logic [rsi_pkg::DV_RW-1:0]   o_rem,
    output logic [rsi_pkg::DV_NW-1:0]   o_quo
);
    import rsi_pkg::*;

    logic [DV_RW-1:0] w_rem2;
    logic [DV_RW-1:0] w_dvs;
    logic             w_ge;
    logic             r_valid;
    t_side            r_side;
    logic [DV_NW-1:0] r_num;
    logic [DV_RW-1:0] r_rem;
    logic [DV_NW-1:0] r_quo;

    // divisor is |d|^2, carried with the word
    assign w_rem2 = {i_rem[DV_RW-2:0], i_num[DV_NW-1]};
    assign w_dvs  = {1'b0, i_side.len2};
    assign w_ge   = (w_rem2 >= w_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_num  <= {i_num[DV_NW-2:0], 1'b0};
            r_rem  <= w_ge ? (w_rem2 - w_dvs) : w_rem2;
            r_quo  <= {i_quo[DV_NW-2:0], w_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule
`default_nettype wire

FILE: rtl/core/ray_sphere_intersect_core.sv
// Pipeline with 16 fraction bits: product stage, 5 multiply cells, 66 square root cells
// (one root bit each), 83 divide cells (one quotient bit each), 2 multiply cells and
// the output register. Throughput: one word per cycle while o_stall is low;
// a skid register behind the output keeps o_stall registered.
// Reset clears the valid bits of every cell and the output/skid flags; data is not reset.
`default_nettype none
module ray_sphere_intersect_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [31:0]          i_origin_x,
    input  logic signed [31:0]          i_origin_y,
    input  logic signed [31:0]          i_origin_z,
    input  logic signed [31:0]          i_dir_x,
    input  logic signed [31:0]          i_dir_y,
    input  logic signed [31:0]          i_dir_z,
    input  logic signed [31:0]          i_centre_x,
    input  logic signed [31:0]          i_centre_y,
    input  logic signed [31:0]          i_centre_z,
    input  logic [30:0]                 i_sphere_radius,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit,
    output logic                        o_bad_direction,
    output logic signed [31:0]          o_near_t,
    output logic signed [31:0]          o_point_x,
    output logic signed [31:0]          o_point_y,
    output logic signed [31:0]          o_point_z
);
    import rsi_pkg::*;

    logic w_adv;

    // product stage
    t_word                  w_org [3];
    t_word                  w_dir [3];
    t_word                  w_ctr [3];
    logic signed [WW:0]     w_rel [3];
    logic signed [LEN_W-1:0] n_pdd [3];
    logic signed [LEN_W:0]  n_prd [3];
    logic signed [LEN_W+1:0] n_prr [3];
    t_side                  n_a_side;
    logic [LEN_W-1:0]       r_pdd [3];
    logic signed [LEN_W:0]  r_prd [3];
    logic [LEN_W:0]         r_prr [3];
    logic [2*WW-3:0]        r_pr2;
    t_side                  r_a_side;
    logic                   r_a_valid;

    // sums feeding the discriminant multipliers
    logic [LEN_W-1:0]       w_len2;
    logic signed [PROJ_W-1:0] w_proj;
    logic [PROJ_W-1:0]      w_pmag;
    logic [CQ_W-1:0]        w_cq;
    logic [CQ_W-1:0]        w_cneg;
    logic [CQ_W-2:0]        w_cmag;
    t_side                  w_b_side;

    logic                   w_mv [MC_N_DSC+1];
    t_side                  w_ms [MC_N_DSC+1];
    logic [MC_AW-1:0]       w_pa [MC_N_DSC+1];
    logic [MC_BW-1:0]       w_pb [MC_N_DSC+1];
    logic [MC_PW-1:0]       w_pc [MC_N_DSC+1];
    logic [MC_AW-1:0]       w_la [MC_N_DSC+1];
    logic [MC_BW-1:0]       w_lb [MC_N_DSC+1];
    logic [MC_PW-1:0]       w_lc [MC_N_DSC+1];

    // square root chain
    logic [DSC_W-1:0]       w_lmag;
    logic [DSC_W-1:0]       w_dsc;
    t_side                  w_c_side;
    logic                   w_sv [SQ_QW+1];
    t_side                  w_ss [SQ_QW+1];
    logic [SQ_NW-1:0]       w_sn [SQ_QW+1];
    logic [SQ_RW-1:0]       w_sr [SQ_QW+1];
    logic [SQ_QW-1:0]       w_sq [SQ_QW+1];

    // divide chain
    logic [NUM_W-1:0]       w_pext;
    logic [NUM_W-1:0]       w_num;
    logic [NUM_W-1:0]       w_nneg;
    logic [NUM_MW-1:0]      w_nmag;
    t_side                  w_d_side;
    logic                   w_dv [DV_NW+1];
    t_side                  w_ds [DV_NW+1];
    logic [DV_NW-1:0]       w_dn [DV_NW+1];
    logic [DV_RW-1:0]       w_dr [DV_NW+1];
    logic [DV_NW-1:0]       w_dq [DV_NW+1];

    // t * d chains
    logic                   w_tv [MC_N_PT+1];
    t_side                  w_ts [MC_N_PT+1];
    logic [MC_AW-1:0]       w_ta [3][MC_N_PT+1];
    logic [MC_BW-1:0]       w_tb [3][MC_N_PT+1];
    logic [MC_PW-1:0]       w_tc [3][MC_N_PT+1];
    logic [WW-1:0]          w_dmag [3];

    // result
    t_side                  w_f_side;
    logic [TERM_W-1:0]      w_term [3];
    logic [SUM_W-1:0]       w_tsum [3];
    logic [SUM_W-1:0]       w_tv_t;
    t_res                   w_res;
    logic                   w_tail_valid;
    t_res                   r_out;
    t_res                   r_skd;
    logic                   r_out_valid;
    logic                   r_skd_full;

    assign w_adv   = !r_skd_full;
    assign o_stall = r_skd_full;

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;
    assign w_ctr[0] = i_centre_x;
    assign w_ctr[1] = i_centre_y;
    assign w_ctr[2] = i_centre_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rel[k] = (WW+1)'(w_org[k]) - (WW+1)'(w_ctr[k]);
            n_pdd[k] = w_dir[k] * w_dir[k];
            n_prd[k] = w_rel[k] * w_dir[k];
            n_prr[k] = w_rel[k] * w_rel[k];
        end
        n_a_side     = '0;
        n_a_side.org = {w_org[2], w_org[1], w_org[0]};
        n_a_side.dir = {w_dir[2], w_dir[1], w_dir[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_pdd[k] <= n_pdd[k];
                r_prd[k] <= n_prd[k];
                r_prr[k] <= n_prr[k][LEN_W:0];
            end
            r_pr2    <= (2*WW-2)'(i_sphere_radius) * (2*WW-2)'(i_sphere_radius);
            r_a_side <= n_a_side;
        end
    end

    always_comb begin
        w_len2 = r_pdd[0] + r_pdd[1] + r_pdd[2];
        w_proj = PROJ_W'(r_prd[0]) + PROJ_W'(r_prd[1]) + PROJ_W'(r_prd[2]);
        w_pmag = w_proj[PROJ_W-1] ? PROJ_W'(-w_proj) : PROJ_W'(w_proj);
        w_cq   = CQ_W'(r_prr[0]) + CQ_W'(r_prr[1]) + CQ_W'(r_prr[2]) - CQ_W'(r_pr2);
        w_cneg = -w_cq;
        w_cmag = w_cq[CQ_W-1] ? w_cneg[CQ_W-2:0] : w_cq[CQ_W-2:0];
        w_b_side        = r_a_side;
        w_b_side.len2   = w_len2;
        w_b_side.proj   = w_proj;
        w_b_side.cq_neg = w_cq[CQ_W-1];
        w_b_side.bad    = (w_len2 == '0);
    end

    assign w_mv[0] = r_a_valid;
    assign w_ms[0] = w_b_side;
    assign w_pa[0] = MC_AW'(w_pmag);
    assign w_pb[0] = MC_BW'(w_pmag);
    assign w_pc[0] = '0;
    assign w_la[0] = MC_AW'(w_len2);
    assign w_lb[0] = MC_BW'(w_cmag);
    assign w_lc[0] = '0;

    for (genvar j = 0; j < MC_N_DSC; j++) begin : g_dsc
        rsi_mul_cell u_psq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_mv[j]),
            .i_side  (w_ms[j]),
            .i_a     (w_pa[j]),
            .i_b     (w_pb[j]),
            .i_acc   (w_pc[j]),
            .o_valid (w_mv[j+1]),
            .o_side  (w_ms[j+1]),
            .o_a     (w_pa[j+1]),
            .o_b     (w_pb[j+1]),
            .o_acc   (w_pc[j+1])
        );
        rsi_mul_cell u_lcq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_mv[j]),
            .i_side  (w_ms[j]),
            .i_a     (w_la[j]),
            .i_b     (w_lb[j]),
            .i_acc   (w_lc[j]),
            .o_valid (),
            .o_side  (),
            .o_a     (w_la[j+1]),
            .o_b     (w_lb[j+1]),
            .o_acc   (w_lc[j+1])
        );
    end

    always_comb begin
        w_lmag = {2'b00, w_lc[MC_N_DSC][DSC_W-3:0]};
        w_dsc  = {2'b00, w_pc[MC_N_DSC][DSC_W-3:0]}
                 + (w_ms[MC_N_DSC].cq_neg ? w_lmag : (~w_lmag + DSC_W'(1)));
        w_c_side     = w_ms[MC_N_DSC];
        w_c_side.hit = !w_dsc[DSC_W-1] && !w_ms[MC_N_DSC].bad;
    end

    assign w_sv[0] = w_mv[MC_N_DSC];
    assign w_ss[0] = w_c_side;
    assign w_sn[0] = w_dsc;
    assign w_sr[0] = '0;
    assign w_sq[0] = '0;

    for (genvar j = 0; j < SQ_QW; j++) begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_sv[j]),
            .i_side  (w_ss[j]),
            .i_num   (w_sn[j]),
            .i_rem   (w_sr[j]),
            .i_root  (w_sq[j]),
            .o_valid (w_sv[j+1]),
            .o_side  (w_ss[j+1]),
            .o_num   (w_sn[j+1]),
            .o_rem   (w_sr[j+1]),
            .o_root  (w_sq[j+1])
        );
    end

    // numerator -h - sqrt(q)
    always_comb begin
        w_pext = {{(NUM_W-PROJ_W){w_ss[SQ_QW].proj[PROJ_W-1]}}, w_ss[SQ_QW].proj};
        w_num  = NUM_W'(0) - w_pext - {2'b00, w_sq[SQ_QW]};
        w_nneg = -w_num;
        w_nmag = w_num[NUM_W-1] ? w_nneg[NUM_MW-1:0] : w_num[NUM_MW-1:0];
        w_d_side         = w_ss[SQ_QW];
        w_d_side.num_neg = w_num[NUM_W-1];
    end

    assign w_dv[0] = w_sv[SQ_QW];
    assign w_ds[0] = w_d_side;
    assign w_dn[0] = {w_nmag, {FRAC_BITS{1'b0}}};
    assign w_dr[0] = '0;
    assign w_dq[0] = '0;

    for (genvar j = 0; j < DV_NW; j++) begin : g_div
        rsi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_dv[j]),
            .i_side  (w_ds[j]),
            .i_num   (w_dn[j]),
            .i_rem   (w_dr[j]),
            .i_quo   (w_dq[j]),
            .o_valid (w_dv[j+1]),
            .o_side  (w_ds[j+1]),
            .o_num   (w_dn[j+1]),
            .o_rem   (w_dr[j+1]),
            .o_quo   (w_dq[j+1])
        );
    end

    assign w_tv[0] = w_dv[DV_NW];
    assign w_ts[0] = w_ds[DV_NW];

    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign w_dmag[k]  = w_ds[DV_NW].dir[k][WW-1] ? WW'(-w_ds[DV_NW].dir[k])
                                                       : WW'(w_ds[DV_NW].dir[k]);
        assign w_ta[k][0] = MC_AW'(w_dq[DV_NW]);
        assign w_tb[k][0] = {w_dmag[k], {(MC_BW-WW){1'b0}}};
        assign w_tc[k][0] = '0;
        for (genvar j = 0; j < MC_N_PT; j++) begin : g_cell
            if (k == 0) begin : g_lead
                rsi_mul_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (w_adv),
                    .i_valid (w_tv[j]),
                    .i_side  (w_ts[j]),
                    .i_a     (w_ta[k][j]),
                    .i_b     (w_tb[k][j]),
                    .i_acc   (w_tc[k][j]),
                    .o_valid (w_tv[j+1]),
                    .o_side  (w_ts[j+1]),
                    .o_a     (w_ta[k][j+1]),
                    .o_b     (w_tb[k][j+1]),
                    .o_acc   (w_tc[k][j+1])
                );
            end else begin : g_follow
                rsi_mul_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (w_adv),
                    .i_valid (w_tv[j]),
                    .i_side  (w_ts[j]),
                    .i_a     (w_ta[k][j]),
                    .i_b     (w_tb[k][j]),
                    .i_acc   (w_tc[k][j]),
                    .o_valid (),
                    .o_side  (),
                    .o_a     (w_ta[k][j+1]),
                    .o_b     (w_tb[k][j+1]),
                    .o_acc   (w_tc[k][j+1])
                );
            end
        end
    end

    // point = o + trunc(t*d / 2^frac), saturated
    always_comb begin
        w_f_side     = w_ts[MC_N_PT];
        w_tail_valid = w_tv[MC_N_PT];
        w_tv_t = w_f_side.num_neg ? -SUM_W'(w_ta[0][MC_N_PT][DV_NW-1:0])
                                  :  SUM_W'(w_ta[0][MC_N_PT][DV_NW-1:0]);
        for (int k = 0; k < 3; k++) begin
            w_term[k] = w_tc[k][MC_N_PT][DV_NW+WW-1:FRAC_BITS];
            w_tsum[k] = SUM_W'(w_f_side.org[k])
                        + ((w_f_side.num_neg ^ w_f_side.dir[k][WW-1])
                           ? -SUM_W'(w_term[k]) : SUM_W'(w_term[k]));
        end
        w_res.hit = w_f_side.hit;
        w_res.bad = w_f_side.bad;
        if (w_f_side.hit) begin
            w_res.near_t = sat32(w_tv_t);
            for (int k = 0; k < 3; k++) begin
                w_res.pt[k] = sat32(w_tsum[k]);
            end
        end else begin
            w_res.near_t = NEG_ONE;
            w_res.pt     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_full  <= 1'b0;
        end else if (r_skd_full) begin
            if (!i_stall) begin
                r_skd_full <= 1'b0;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= w_tail_valid;
        end else if (w_tail_valid) begin
            r_skd_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_full) begin
            if (!i_stall) begin
                r_out <= r_skd;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out <= w_res;
        end else begin
            r_skd <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out.hit;
    assign o_bad_direction = r_out.bad;
    assign o_near_t        = r_out.near_t;
    assign o_point_x       = r_out.pt[0];
    assign o_point_y       = r_out.pt[1];
    assign o_point_z       = r_out.pt[2];

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_full |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skd_full && i_stall) |=> (r_skd_full && $stable(r_skd)))
        else $error("skid word lost while stalled");

    a_hit_good_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> !o_bad_direction)
        else $error("hit reported for zero direction");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_near_t == NEG_ONE && o_point_x == '0
                                 && o_point_y == '0 && o_point_z == '0))
        else $error("miss word carries non-default fields");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_ray_sphere_intersect_core.sv
`default_nettype none
module tb_ray_sphere_intersect_core;
    import rsi_pkg::*;

    localparam int   N_RANDOM = 1930;
    localparam int   LAT      = 158;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    typedef struct packed {
        t_word [2:0] org;
        t_word [2:0] dir;
        t_word [2:0] ctr;
        logic [30:0] rad;
    } ray_t;

    typedef struct {
        ray_t w;
        t_res r;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic signed [31:0] i_centre_x = '0, i_centre_y = '0, i_centre_z = '0;
    logic [30:0] i_sphere_radius = '0;
    logic o_stall, o_valid, o_hit, o_bad_direction;
    logic signed [31:0] o_near_t, o_point_x, o_point_y, o_point_z;

    ray_sphere_intersect_core dut (.*);

    row_t  ray_queue[$];
    t_res  hit_queue[$];
    row_t  cur;
    int    cyc = 0;
    int    hold_cyc = 0;
    int    mismatches = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [255:0] isqrt256(input logic [255:0] n);
        logic [255:0] r, b;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            b = r | (256'd1 << i);
            if (b * b <= n) r = b;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [255:0] v);
        if (v > 256'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -256'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_res trace_sphere(input ray_t s);
        logic signed [255:0] rel, len2, proj, cq, dsc, num, tq, term, rr;
        t_res r;
        len2 = '0;
        proj = '0;
        cq   = '0;
        for (int k = 0; k < 3; k++) begin
            rel  = $signed(s.org[k]) - $signed(s.ctr[k]);
            len2 = len2 + $signed(s.dir[k]) * $signed(s.dir[k]);
            proj = proj + rel * $signed(s.dir[k]);
            cq   = cq + rel * rel;
        end
        rr  = $signed({225'd0, s.rad});
        cq  = cq - rr * rr;
        dsc = proj * proj - len2 * cq;
        r.hit    = 1'b0;
        r.bad    = (len2 == 0);
        r.near_t = NEG_ONE;
        r.pt     = '0;
        if (!r.bad && dsc >= 0) begin
            num = -proj - $signed(isqrt256(dsc));
            tq  = (num <<< FRAC_BITS) / len2;
            r.hit    = 1'b1;
            r.near_t = clamp32(tq);
            for (int k = 0; k < 3; k++) begin
                term = (tq * $signed(s.dir[k])) / (256'sd1 <<< FRAC_BITS);
                r.pt[k] = clamp32($signed(s.org[k]) + term);
            end
        end
        return r;
    endfunction

    function automatic ray_t mk_ray(input t_word ox, oy, oz, dx, dy, dz,
                                    input t_word cx, cy, cz, input logic [30:0] rad);
        ray_t s;
        s.org = {oz, oy, ox};
        s.dir = {dz, dy, dx};
        s.ctr = {cz, cy, cx};
        s.rad = rad;
        return s;
    endfunction

    function automatic t_res mk_res(input logic h, b, input t_word t, px, py, pz);
        t_res r;
        r.hit = h;
        r.bad = b;
        r.near_t = t;
        r.pt = {pz, py, px};
        return r;
    endfunction

    function automatic t_word scene_coord(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_word mixed_word();
        t_word v;
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic ray_t random_ray();
        ray_t s;
        int sel, k;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
        end else if (sel < 40) begin
            for (k = 0; k < 3; k++) begin
                s.org[k] = mixed_word();
                s.dir[k] = mixed_word();
                s.ctr[k] = mixed_word();
            end
            s.rad = 31'($urandom >> $urandom_range(1, 31));
        end else begin
            // aim the ray roughly at the sphere so most of these hit
            k = $urandom_range(0, 8);
            for (int j = 0; j < 3; j++) begin
                s.org[j] = scene_coord(100 << 16);
                s.dir[j] = scene_coord(2 << 16);
                s.ctr[j] = s.org[j] + ((s.dir[j] >>> 2) * k) + scene_coord(4 << 16);
            end
            if ($urandom_range(0, 19) == 0) s.dir = '0;
            s.rad = 31'($urandom_range(0, 50 << 16));
        end
        return s;
    endfunction

    task automatic add_row(input ray_t s);
        row_t rw;
        rw.w = s;
        rw.r = trace_sphere(s);
        ray_queue = {ray_queue, rw};
    endtask

    task automatic add_typed(input ray_t s, input t_res r);
        row_t rw;
        rw.w = s;
        rw.r = r;
        ray_queue = {ray_queue, rw};
    endtask

    always @(posedge i_clk) cyc <= cyc + 1;

    // sender
    always @(posedge i_clk) begin
        logic take;
        take = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) hit_queue = {hit_queue, cur.r};
            if (!i_valid || !o_stall) begin
                if (ray_queue.size() > 0 &&
                    ((cyc > 1500 && cyc < 2200) || $urandom_range(0, 99) >= 33)) begin
                    cur = ray_queue.pop_front();
                    take = 1'b1;
                end
                i_valid <= take;
                if (take) begin
                    i_origin_x <= cur.w.org[0];
                    i_origin_y <= cur.w.org[1];
                    i_origin_z <= cur.w.org[2];
                    i_dir_x <= cur.w.dir[0];
                    i_dir_y <= cur.w.dir[1];
                    i_dir_z <= cur.w.dir[2];
                    i_centre_x <= cur.w.ctr[0];
                    i_centre_y <= cur.w.ctr[1];
                    i_centre_z <= cur.w.ctr[2];
                    i_sphere_radius <= cur.w.rad;
                end
            end
        end
    end

    // receiver: early long hold-off that backs the pipe up, later a quiet stretch
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n) begin
            hold_cyc <= hold_cyc + 1;
            if (o_valid && !i_stall) begin
                if (hit_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word at cycle %0d", cyc);
                end else begin
                    e = hit_queue.pop_front();
                    if (o_hit !== e.hit || o_bad_direction !== e.bad ||
                        o_near_t !== e.near_t || o_point_x !== e.pt[0] ||
                        o_point_y !== e.pt[1] || o_point_z !== e.pt[2]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %b %b %h %h %h %h, got %b %b %h %h %h %h",
                                e.hit, e.bad, e.near_t, e.pt[0], e.pt[1], e.pt[2],
                                o_hit, o_bad_direction, o_near_t,
                                o_point_x, o_point_y, o_point_z);
                    end
                end
            end
            if (cyc > 1500 && cyc < 2200) i_stall <= 1'b0;
            else if (hold_cyc >= 400 && hold_cyc < 700) i_stall <= 1'b1;
            else i_stall <= ($urandom_range(0, 99) < 33);
        end
    end

    initial begin
        add_typed(mk_ray(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0, 31'(ONE)),
                  mk_res(0, 1, NEG_ONE, 0, 0, 0));
        add_typed(mk_ray(0, 0, 0, ONE, 0, 0, 0, 10 * ONE, 0, 31'(ONE)),
                  mk_res(0, 0, NEG_ONE, 0, 0, 0));
        add_typed(mk_ray(0, 0, -5 * ONE, 0, 0, ONE, 0, 0, 0, 31'(ONE)),
                  mk_res(1, 0, 4 * ONE, 0, 0, -ONE));
        add_typed(mk_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 31'(2 * ONE)),
                  mk_res(1, 0, -2 * ONE, -2 * ONE, 0, 0));
        add_typed(mk_ray(0, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, '1),
                  mk_res(0, 1, NEG_ONE, 0, 0, 0));
        add_row(mk_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
        add_row(mk_ray(0, ONE, 0, ONE, 0, 0, 5 * ONE, 0, 0, 31'(ONE)));
        add_row(mk_ray('1, '1, '1, 1, 1, 1, '0, '0, '0, '1));
        add_row(mk_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '1));
        add_row(mk_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1));
        add_row(mk_ray(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0,
                       32'sh7FFF_FFFF, 0, 0, '1));
        add_row(mk_ray(0, 0, 0, 1, 0, 0, 32'sh7FFF_FFFF, 0, 0, '1));
        add_row(mk_ray(0, 0, 0, 0, 0, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 31'(ONE)));
        add_row(mk_ray(10 * ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, 31'(3 * ONE)));
        add_row(mk_ray(0, 0, 0, ONE, ONE, 0, 5 * ONE, 5 * ONE, 0, 31'(ONE)));
        add_row(mk_ray(0, 0, 0, 1, 1, 1, 0, 0, 0, 31'd1));
        add_row(mk_ray(ONE, ONE, ONE, 2, 0, 0, 32'sh7FFF_0000, ONE, ONE, 31'd2));
        for (int n = 0; n < N_RANDOM; n++) add_row(random_ray());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (ray_queue.size() != 0 || i_valid || hit_queue.size() != 0)
            @(posedge i_clk);
        repeat (LAT + 50) @(posedge i_clk);
        if (mismatches == 0 && hit_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
